@@ rtl/kpp_pkg.sv @@
// ----------------------------------------------------------------------------
// kpp_pkg: shared types and constants of the kinematic path predictor
// Item and result structs, configuration image, job descriptor, widths,
// register and model codes, and the Q16.16 rounding/saturation helpers.
// ----------------------------------------------------------------------------
package kpp_pkg;

	// Field widths
	localparam int unsigned VAL_W   = 32;   // Q16.16 value
	localparam int unsigned DT_W    = 20;   // step time
	localparam int unsigned HOR_W   = 24;   // horizon / reported time
	localparam int unsigned LIM_W   = 25;   // horizon plus tolerance
	localparam int unsigned T_W     = 26;   // exact i*dt, i <= 64
	localparam int unsigned T1_W    = 27;   // exact (i+1)*dt
	localparam int unsigned DT2_W   = 40;   // dt*dt
	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 21;
	localparam int unsigned MUL_P_W = 54;
	localparam int unsigned VDT_W   = 52;   // 32 x 20 product
	localparam int unsigned ADT2_W  = 72;   // a*dt*dt
	localparam int unsigned LIN_W   = 59;   // running sum of a 32 x 20 product
	localparam int unsigned QUAD_W  = 85;   // running a*t*t
	localparam int unsigned DIF_W   = 81;   // its first difference
	localparam int unsigned LIN_TERM_W  = LIN_W - 16;
	localparam int unsigned QUAD_TERM_W = QUAD_W - 33;
	localparam int unsigned SUM_W   = 54;
	localparam int unsigned SD_W    = 44;
	localparam int unsigned CFG_IDX_W = 3;

	// Job queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODEL     = 3'd0,
		REG_STEP_TIME = 3'd1,
		REG_HORIZON   = 3'd2,
		REG_INIT_SD   = 3'd3,
		REG_SD_GROWTH = 3'd4
	} reg_index_t;

	// Predictor selector codes; the unused code behaves as constant velocity
	localparam logic [1:0] MODEL_CV  = 2'd0;
	localparam logic [1:0] MODEL_CA  = 2'd1;
	localparam logic [1:0] MODEL_UNC = 2'd2;

	typedef struct packed {
		logic [1:0]       predictor_model;
		logic [DT_W-1:0]  step_time;
		logic [HOR_W-1:0] horizon_time;
		logic [VAL_W-1:0] initial_stddev;
		logic [VAL_W-1:0] stddev_growth;
	} cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] pos_x;
		logic signed [VAL_W-1:0] pos_y;
		logic signed [VAL_W-1:0] vel_x;
		logic signed [VAL_W-1:0] vel_y;
		logic signed [VAL_W-1:0] acc_x;
		logic signed [VAL_W-1:0] acc_y;
	} in_item_t;

	typedef struct packed {
		logic [HOR_W-1:0]        pred_time;
		logic signed [VAL_W-1:0] pred_pos_x;
		logic signed [VAL_W-1:0] pred_pos_y;
		logic signed [VAL_W-1:0] pred_vel_x;
		logic signed [VAL_W-1:0] pred_vel_y;
		logic [VAL_W-1:0]        pred_stddev;
		logic                    last_step;
	} result_t;

	// Per-item step increments prepared by the front
	typedef struct packed {
		logic signed [VAL_W-1:0]  pos_x;
		logic signed [VAL_W-1:0]  pos_y;
		logic signed [VAL_W-1:0]  vel_x;
		logic signed [VAL_W-1:0]  vel_y;
		logic signed [VDT_W-1:0]  vdt_x;
		logic signed [VDT_W-1:0]  vdt_y;
		logic signed [VDT_W-1:0]  adt_x;
		logic signed [VDT_W-1:0]  adt_y;
		logic signed [ADT2_W-1:0] adt2_x;
		logic signed [ADT2_W-1:0] adt2_y;
		logic [VDT_W-1:0]         sdt;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// x / 2^16 rounded toward zero
	function automatic logic signed [LIN_TERM_W-1:0] trunc_lin(
		input logic signed [LIN_W-1:0] x);
		logic [LIN_W-1:0] biased;
		biased = x + (x[LIN_W-1] ? {{(LIN_W-16){1'b0}}, {16{1'b1}}} : '0);
		return biased[LIN_W-1:16];
	endfunction

	// x / 2^33 rounded toward zero
	function automatic logic signed [QUAD_TERM_W-1:0] trunc_quad(
		input logic signed [QUAD_W-1:0] x);
		logic [QUAD_W-1:0] biased;
		biased = x + (x[QUAD_W-1] ? {{(QUAD_W-33){1'b0}}, {33{1'b1}}} : '0);
		return biased[QUAD_W-1:33];
	endfunction

	// Clamp to the signed 32-bit range
	function automatic logic signed [VAL_W-1:0] sat_s32(
		input logic signed [SUM_W-1:0] x);
		logic signed [VAL_W-1:0] y;
		if (!x[SUM_W-1] && (|x[SUM_W-2:VAL_W-1])) begin
			y = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (x[SUM_W-1] && !(&x[SUM_W-2:VAL_W-1])) begin
			y = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			y = x[VAL_W-1:0];
		end
		return y;
	endfunction

endpackage

@@ rtl/kpp_front.sv @@
// ----------------------------------------------------------------------------
// kpp_front: item intake and per-run setup
// Accepts an item, drops runs with no steps, and works out the per-step
// increments on one shared multiplier before handing a job to the queue.
// ----------------------------------------------------------------------------
module kpp_front #(
	parameter int unsigned TIME_TOLERANCE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kpp_pkg::cfg_t     cfg,
	input  logic              start,
	input  kpp_pkg::in_item_t item,
	output logic              busy,
	input  logic              q_full,
	output logic              push,
	output kpp_pkg::job_t     job
);

	typedef enum logic [2:0] {
		FR_IDLE = 3'b001,
		FR_CALC = 3'b010,
		FR_PUSH = 3'b100
	} fr_state_t;

	typedef enum logic [3:0] {
		OP_DT2   = 4'd0,
		OP_VDT_X = 4'd1,
		OP_VDT_Y = 4'd2,
		OP_ADT_X = 4'd3,
		OP_ADT_Y = 4'd4,
		OP_SDT   = 4'd5,
		OP_AX_LO = 4'd6,
		OP_AX_HI = 4'd7,
		OP_AY_LO = 4'd8,
		OP_AY_HI = 4'd9
	} mul_op_t;

	fr_state_t state_q;
	mul_op_t   op_q;
	mul_op_t   mul_op_s1;
	logic      iss_q;
	logic      mul_vld_s1;

	logic signed [kpp_pkg::MUL_P_W-1:0] mul_p_s1;
	logic signed [kpp_pkg::MUL_A_W-1:0] a_op;
	logic signed [kpp_pkg::MUL_B_W-1:0] b_op;
	logic signed [kpp_pkg::MUL_P_W-1:0] prod;
	logic [kpp_pkg::DT2_W-1:0]          dt2_q;
	logic signed [kpp_pkg::VAL_W-1:0]   acc_x_q;
	logic signed [kpp_pkg::VAL_W-1:0]   acc_y_q;
	kpp_pkg::job_t                      job_q;

	logic [kpp_pkg::LIM_W-1:0] limit;
	logic                      run_empty;
	logic                      accept;
	logic                      calc_done;

	assign limit = kpp_pkg::LIM_W'(cfg.horizon_time) + kpp_pkg::LIM_W'(TIME_TOLERANCE);
	assign run_empty = (cfg.step_time == '0) || (cfg.horizon_time == '0) ||
		(kpp_pkg::LIM_W'(cfg.step_time) > limit);
	assign accept    = start && (state_q == FR_IDLE);
	assign calc_done = mul_vld_s1 && (mul_op_s1 == OP_AY_HI);
	assign busy      = (state_q != FR_IDLE);
	assign push      = (state_q == FR_PUSH) && !q_full;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FR_IDLE;
			iss_q      <= 1'b0;
			op_q       <= OP_DT2;
			mul_op_s1  <= OP_DT2;
			mul_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				FR_IDLE: begin
					if (accept && !run_empty) begin
						state_q <= FR_CALC;
					end
				end
				FR_CALC: begin
					if (calc_done) begin
						state_q <= FR_PUSH;
					end
				end
				FR_PUSH: begin
					if (!q_full) begin
						state_q <= FR_IDLE;
					end
				end
				default: state_q <= FR_IDLE;
			endcase
			if (accept && !run_empty) begin
				iss_q <= 1'b1;
				op_q  <= OP_DT2;
			end else if (iss_q) begin
				if (op_q == OP_AY_HI) begin
					iss_q <= 1'b0;
				end
				op_q <= mul_op_t'(op_q + 4'd1);
			end
			mul_vld_s1 <= iss_q;
			mul_op_s1  <= op_q;
		end
	end

	always_comb begin
		a_op = '0;
		b_op = {1'b0, cfg.step_time};
		unique case (op_q)
			OP_DT2:   a_op = {13'b0, cfg.step_time};
			OP_VDT_X: a_op = {job_q.vel_x[kpp_pkg::VAL_W-1], job_q.vel_x};
			OP_VDT_Y: a_op = {job_q.vel_y[kpp_pkg::VAL_W-1], job_q.vel_y};
			OP_ADT_X: a_op = {acc_x_q[kpp_pkg::VAL_W-1], acc_x_q};
			OP_ADT_Y: a_op = {acc_y_q[kpp_pkg::VAL_W-1], acc_y_q};
			OP_SDT:   a_op = {1'b0, cfg.stddev_growth};
			OP_AX_LO: begin
				a_op = {acc_x_q[kpp_pkg::VAL_W-1], acc_x_q};
				b_op = {1'b0, dt2_q[19:0]};
			end
			OP_AX_HI: begin
				a_op = {acc_x_q[kpp_pkg::VAL_W-1], acc_x_q};
				b_op = {1'b0, dt2_q[39:20]};
			end
			OP_AY_LO: begin
				a_op = {acc_y_q[kpp_pkg::VAL_W-1], acc_y_q};
				b_op = {1'b0, dt2_q[19:0]};
			end
			OP_AY_HI: begin
				a_op = {acc_y_q[kpp_pkg::VAL_W-1], acc_y_q};
				b_op = {1'b0, dt2_q[39:20]};
			end
			default: ;
		endcase
	end

	assign prod = a_op * b_op;

	// Payload: item capture, product register and job assembly
	always_ff @(posedge clk) begin
		if (accept && !run_empty) begin
			job_q.pos_x <= item.pos_x;
			job_q.pos_y <= item.pos_y;
			job_q.vel_x <= item.vel_x;
			job_q.vel_y <= item.vel_y;
			acc_x_q     <= item.acc_x;
			acc_y_q     <= item.acc_y;
		end
		mul_p_s1 <= prod;
		if (mul_vld_s1) begin
			case (mul_op_s1)
				OP_DT2:   dt2_q <= mul_p_s1[kpp_pkg::DT2_W-1:0];
				OP_VDT_X: job_q.vdt_x <= mul_p_s1[kpp_pkg::VDT_W-1:0];
				OP_VDT_Y: job_q.vdt_y <= mul_p_s1[kpp_pkg::VDT_W-1:0];
				OP_ADT_X: job_q.adt_x <= mul_p_s1[kpp_pkg::VDT_W-1:0];
				OP_ADT_Y: job_q.adt_y <= mul_p_s1[kpp_pkg::VDT_W-1:0];
				OP_SDT:   job_q.sdt   <= mul_p_s1[kpp_pkg::VDT_W-1:0];
				OP_AX_LO: job_q.adt2_x <= kpp_pkg::ADT2_W'(mul_p_s1);
				OP_AX_HI: job_q.adt2_x <= job_q.adt2_x +
					{mul_p_s1[kpp_pkg::VDT_W-1:0], 20'b0};
				OP_AY_LO: job_q.adt2_y <= kpp_pkg::ADT2_W'(mul_p_s1);
				OP_AY_HI: job_q.adt2_y <= job_q.adt2_y +
					{mul_p_s1[kpp_pkg::VDT_W-1:0], 20'b0};
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !run_empty) |=> (busy && iss_q))
		else $error("front did not start setup after taking an item");

endmodule

@@ rtl/kpp_queue.sv @@
// ----------------------------------------------------------------------------
// kpp_queue: job queue between front and back
// Small FIFO of prepared jobs; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module kpp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kpp_pkg::job_t    wdata,
	input  logic             pop,
	output kpp_pkg::job_t    rdata,
	output kpp_pkg::q_stat_t stat
);

	kpp_pkg::job_t mem_q [kpp_pkg::QUEUE_DEPTH];

	logic [kpp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [kpp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [kpp_pkg::QCNT_W-1:0] cnt_q;

	function automatic logic [kpp_pkg::QPTR_W-1:0] ptr_inc(
		input logic [kpp_pkg::QPTR_W-1:0] p);
		logic [kpp_pkg::QPTR_W-1:0] n;
		if (p == kpp_pkg::QPTR_W'(kpp_pkg::QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + kpp_pkg::QPTR_W'(1);
		end
		return n;
	endfunction

	assign stat.full  = (cnt_q == kpp_pkg::QCNT_W'(kpp_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + kpp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - kpp_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !stat.full)
		else $error("job pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !stat.empty)
		else $error("job popped from an empty queue");

endmodule

@@ rtl/kpp_back.sv @@
// ----------------------------------------------------------------------------
// kpp_back: step generator
// Runs one job as a stream of predicted states, one step per cycle, by
// accumulating exact products and rounding/saturating in two stages.
// ----------------------------------------------------------------------------
module kpp_back #(
	parameter int unsigned MAX_STEPS      = 64,
	parameter int unsigned TIME_TOLERANCE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kpp_pkg::cfg_t    cfg,
	input  kpp_pkg::q_stat_t q_stat,
	input  kpp_pkg::job_t    q_data,
	output logic             pop,
	output kpp_pkg::result_t result,
	output logic             result_valid
);

	localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_RUN  = 2'b10
	} bk_state_t;

	bk_state_t   state_q;
	logic [STEP_W-1:0] step_q;
	kpp_pkg::job_t     job_cur_q;

	logic [kpp_pkg::T_W-1:0]           t_q;
	logic signed [kpp_pkg::LIN_W-1:0]  v_x_q, v_y_q, a_x_q, a_y_q;
	logic [kpp_pkg::LIN_W-1:0]         s_q;
	logic signed [kpp_pkg::QUAD_W-1:0] q_x_q, q_y_q;
	logic signed [kpp_pkg::DIF_W-1:0]  dn_x_q, dn_y_q;

	logic [kpp_pkg::LIM_W-1:0] limit;
	logic [kpp_pkg::T1_W-1:0]  next_t;
	logic                      last_now;

	// Stage 1: rounded terms
	logic                                   valid_s1;
	logic                                   last_s1;
	logic [kpp_pkg::HOR_W-1:0]              time_s1;
	logic signed [kpp_pkg::VAL_W-1:0]       px_s1, py_s1, vx_s1, vy_s1;
	logic signed [kpp_pkg::LIN_TERM_W-1:0]  vt_x_s1, vt_y_s1, at_x_s1, at_y_s1;
	logic signed [kpp_pkg::QUAD_TERM_W-1:0] qt_x_s1, qt_y_s1;
	logic [kpp_pkg::LIN_TERM_W-1:0]         st_s1;

	// Stage 2: sums and saturation
	logic                              is_ca, is_unc;
	logic signed [kpp_pkg::SUM_W-1:0]  pos_x_sum, pos_y_sum, vel_x_sum, vel_y_sum;
	logic [kpp_pkg::SD_W-1:0]          sd_sum;
	kpp_pkg::result_t                  res_d;
	kpp_pkg::result_t                  result_q;
	logic                              result_valid_q;

	assign limit    = kpp_pkg::LIM_W'(cfg.horizon_time) + kpp_pkg::LIM_W'(TIME_TOLERANCE);
	assign next_t   = kpp_pkg::T1_W'(t_q) + kpp_pkg::T1_W'(cfg.step_time);
	assign last_now = (step_q == STEP_W'(MAX_STEPS)) || (next_t > kpp_pkg::T1_W'(limit));
	assign pop      = (state_q == BK_IDLE) && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_IDLE;
			step_q         <= '0;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (!q_stat.empty) begin
						state_q <= BK_RUN;
						step_q  <= STEP_W'(1);
					end
				end
				BK_RUN: begin
					step_q <= step_q + STEP_W'(1);
					if (last_now) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
			valid_s1       <= (state_q == BK_RUN);
			result_valid_q <= valid_s1;
		end
	end

	// Accumulators hold the exact products of the current step
	always_ff @(posedge clk) begin
		if (pop) begin
			job_cur_q <= q_data;
			t_q    <= kpp_pkg::T_W'(cfg.step_time);
			v_x_q  <= kpp_pkg::LIN_W'(q_data.vdt_x);
			v_y_q  <= kpp_pkg::LIN_W'(q_data.vdt_y);
			a_x_q  <= kpp_pkg::LIN_W'(q_data.adt_x);
			a_y_q  <= kpp_pkg::LIN_W'(q_data.adt_y);
			s_q    <= kpp_pkg::LIN_W'(q_data.sdt);
			q_x_q  <= kpp_pkg::QUAD_W'(q_data.adt2_x);
			q_y_q  <= kpp_pkg::QUAD_W'(q_data.adt2_y);
			dn_x_q <= kpp_pkg::DIF_W'(q_data.adt2_x) + (kpp_pkg::DIF_W'(q_data.adt2_x) <<< 1);
			dn_y_q <= kpp_pkg::DIF_W'(q_data.adt2_y) + (kpp_pkg::DIF_W'(q_data.adt2_y) <<< 1);
		end else if (state_q == BK_RUN) begin
			t_q    <= t_q + kpp_pkg::T_W'(cfg.step_time);
			v_x_q  <= v_x_q + kpp_pkg::LIN_W'(job_cur_q.vdt_x);
			v_y_q  <= v_y_q + kpp_pkg::LIN_W'(job_cur_q.vdt_y);
			a_x_q  <= a_x_q + kpp_pkg::LIN_W'(job_cur_q.adt_x);
			a_y_q  <= a_y_q + kpp_pkg::LIN_W'(job_cur_q.adt_y);
			s_q    <= s_q + kpp_pkg::LIN_W'(job_cur_q.sdt);
			q_x_q  <= q_x_q + kpp_pkg::QUAD_W'(dn_x_q);
			q_y_q  <= q_y_q + kpp_pkg::QUAD_W'(dn_y_q);
			dn_x_q <= dn_x_q + (kpp_pkg::DIF_W'(job_cur_q.adt2_x) <<< 1);
			dn_y_q <= dn_y_q + (kpp_pkg::DIF_W'(job_cur_q.adt2_y) <<< 1);
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= last_now;
		time_s1 <= (|t_q[kpp_pkg::T_W-1:kpp_pkg::HOR_W]) ? '1 : t_q[kpp_pkg::HOR_W-1:0];
		px_s1   <= job_cur_q.pos_x;
		py_s1   <= job_cur_q.pos_y;
		vx_s1   <= job_cur_q.vel_x;
		vy_s1   <= job_cur_q.vel_y;
		vt_x_s1 <= kpp_pkg::trunc_lin(v_x_q);
		vt_y_s1 <= kpp_pkg::trunc_lin(v_y_q);
		at_x_s1 <= kpp_pkg::trunc_lin(a_x_q);
		at_y_s1 <= kpp_pkg::trunc_lin(a_y_q);
		qt_x_s1 <= kpp_pkg::trunc_quad(q_x_q);
		qt_y_s1 <= kpp_pkg::trunc_quad(q_y_q);
		st_s1   <= s_q[kpp_pkg::LIN_W-1:16];
	end

	assign is_ca  = (cfg.predictor_model == kpp_pkg::MODEL_CA);
	assign is_unc = (cfg.predictor_model == kpp_pkg::MODEL_UNC);

	always_comb begin
		pos_x_sum = kpp_pkg::SUM_W'(px_s1) + kpp_pkg::SUM_W'(vt_x_s1) +
			(is_ca ? kpp_pkg::SUM_W'(qt_x_s1) : kpp_pkg::SUM_W'(0));
		pos_y_sum = kpp_pkg::SUM_W'(py_s1) + kpp_pkg::SUM_W'(vt_y_s1) +
			(is_ca ? kpp_pkg::SUM_W'(qt_y_s1) : kpp_pkg::SUM_W'(0));
		vel_x_sum = kpp_pkg::SUM_W'(vx_s1) +
			(is_ca ? kpp_pkg::SUM_W'(at_x_s1) : kpp_pkg::SUM_W'(0));
		vel_y_sum = kpp_pkg::SUM_W'(vy_s1) +
			(is_ca ? kpp_pkg::SUM_W'(at_y_s1) : kpp_pkg::SUM_W'(0));
		sd_sum = kpp_pkg::SD_W'(cfg.initial_stddev) +
			(is_unc ? kpp_pkg::SD_W'(st_s1) : kpp_pkg::SD_W'(0));

		res_d.pred_time   = time_s1;
		res_d.pred_pos_x  = kpp_pkg::sat_s32(pos_x_sum);
		res_d.pred_pos_y  = kpp_pkg::sat_s32(pos_y_sum);
		res_d.pred_vel_x  = kpp_pkg::sat_s32(vel_x_sum);
		res_d.pred_vel_y  = kpp_pkg::sat_s32(vel_y_sum);
		res_d.pred_stddev = (|sd_sum[kpp_pkg::SD_W-1:kpp_pkg::VAL_W]) ? '1 :
			sd_sum[kpp_pkg::VAL_W-1:0];
		res_d.last_step   = last_s1;
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN) |-> ((step_q != '0) && (step_q <= STEP_W'(MAX_STEPS))))
		else $error("step counter out of range during a run");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (result_valid && result.last_step))
		else $error("final step lost between rounding and output stage");

endmodule

@@ rtl/kinematic_path_predictor.sv @@
// ----------------------------------------------------------------------------
// kinematic_path_predictor: 2D motion extrapolation over a time horizon
// Output: after an item is taken, its predicted states come one per cycle
//   until the run ends.
// Overlap: the front runs the 10-op setup for the next item on its shared
//   multiplier while the back's one-step-per-cycle loop streams the current run.
// Reset: control clears at once and registers take their documented defaults;
//   results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module kinematic_path_predictor #(
	parameter int unsigned MAX_STEPS      = 64,
	parameter int unsigned TIME_TOLERANCE = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item intake
	input  logic                            start,
	output logic                            busy,
	input  kpp_pkg::in_item_t               item,
	// predicted states
	output logic                            result_valid,
	output kpp_pkg::result_t                result,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kpp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kpp_pkg::VAL_W-1:0]       cfg_data
);

	// Register file, read live by both halves with no copy per job. Writes must
	// come only while the block is idle; the block itself does not enforce it.
	kpp_pkg::cfg_t    cfg_q;

	// Front to queue
	logic             push;
	kpp_pkg::job_t    push_job;

	// Queue to back
	logic             pop;
	kpp_pkg::job_t    head_job;
	kpp_pkg::q_stat_t q_stat;

	// Registers are always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.predictor_model <= kpp_pkg::MODEL_CV;
			cfg_q.step_time       <= 20'd6554;
			cfg_q.horizon_time    <= 24'd196608;
			cfg_q.initial_stddev  <= '0;
			cfg_q.stddev_growth   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			// Mask to register width; drop writes to unknown indexes
			unique case (cfg_index)
				kpp_pkg::REG_MODEL:     cfg_q.predictor_model <= cfg_data[1:0];
				kpp_pkg::REG_STEP_TIME: cfg_q.step_time <= cfg_data[kpp_pkg::DT_W-1:0];
				kpp_pkg::REG_HORIZON:   cfg_q.horizon_time <= cfg_data[kpp_pkg::HOR_W-1:0];
				kpp_pkg::REG_INIT_SD:   cfg_q.initial_stddev <= cfg_data;
				kpp_pkg::REG_SD_GROWTH: cfg_q.stddev_growth <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: take the item, drop empty runs (zero step, zero horizon, or a
	// step longer than horizon plus tolerance), then compute the per-step
	// increments v*dt, a*dt, a*dt*dt and growth*dt on one shared multiplier.
	kpp_front #(
		.TIME_TOLERANCE(TIME_TOLERANCE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.q_full (q_stat.full),
		.push   (push),
		.job    (push_job)
	);

	// Two-entry job queue: the front prepares the next item while the back
	// is still streaming the current run.
	kpp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (head_job),
		.stat   (q_stat)
	);

	// Back: advance exact accumulators one step per cycle, round toward zero,
	// sum per model and saturate. The run ends at the step cap or when the
	// next step would pass horizon plus tolerance.
	kpp_back #(
		.MAX_STEPS      (MAX_STEPS),
		.TIME_TOLERANCE (TIME_TOLERANCE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_stat       (q_stat),
		.q_data       (head_job),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
